>>> hw/rtl/tmlc_pkg.sv
`default_nettype none

package tmlc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int LEVEL_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_CMP,
    S_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  localparam cfg_idx_t REG_DARK   = 3'd0;
  localparam cfg_idx_t REG_SHADY  = 3'd1;
  localparam cfg_idx_t REG_MEDIUM = 3'd2;
  localparam cfg_idx_t REG_LIGHT  = 3'd3;
  localparam cfg_idx_t REG_WATER  = 3'd4;

  localparam sample_t DARK_RST   = 12'd500;
  localparam sample_t SHADY_RST  = 12'd1200;
  localparam sample_t MEDIUM_RST = 12'd2000;
  localparam sample_t LIGHT_RST  = 12'd3000;
  localparam sample_t WATER_RST  = 12'd1000;

  localparam level_t LVL_DARK   = 3'd0;
  localparam level_t LVL_SHADY  = 3'd1;
  localparam level_t LVL_MEDIUM = 3'd2;
  localparam level_t LVL_LIGHT  = 3'd3;
  localparam level_t LVL_BRIGHT = 3'd4;

  function automatic level_t classify(input sample_t mean, input sample_t dark,
                                      input sample_t shady, input sample_t medium_lim,
                                      input sample_t light);
    level_t lvl;
    if (mean <= dark) begin
      lvl = LVL_DARK;
    end else if (mean <= shady) begin
      lvl = LVL_SHADY;
    end else if (mean <= medium_lim) begin
      lvl = LVL_MEDIUM;
    end else if (mean <= light) begin
      lvl = LVL_LIGHT;
    end else begin
      lvl = LVL_BRIGHT;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/trimmed_mean_level_classifier.sv
// A sample that does not close a batch is written to the sample memory. The closing
// beat starts a rank pass (one compare per cycle on the memory read port), then divide
// start, reciprocal multiply and result load: result_valid rises once the output is free.
// Throughput: one sample per cycle in a batch; no input from closing beat to result load.
// Reset (rst, synchronous): empty batch, no result pending, thresholds to defaults.
`default_nettype none

module trimmed_mean_level_classifier #(
  parameter int SAMPLE_COUNT = 10,
  parameter int TRIM_DIVIDER = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_ready,
  input  wire tmlc_pkg::sample_t   sample,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output tmlc_pkg::sample_t        trimmed_mean,
  output tmlc_pkg::level_t         light_level,
  output logic                     water_present,
  input  wire logic                cfg_write,
  input  wire tmlc_pkg::cfg_idx_t  cfg_index,
  input  wire tmlc_pkg::sample_t   cfg_data
);
  import tmlc_pkg::*;

  localparam int TRIM      = SAMPLE_COUNT / TRIM_DIVIDER;
  localparam int MID_COUNT = SAMPLE_COUNT - 2 * TRIM;
  localparam int IDX_W     = $clog2(SAMPLE_COUNT);
  localparam int CNT_W     = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W     = $clog2(SAMPLE_COUNT * SAMPLE_MAX + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SAMPLE_COUNT - 1);

  state_t state, state_next;

  sample_t dark_limit, shady_limit, medium_limit, light_limit, water_threshold;

  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [CNT_W-1:0] rank;
  sample_t          key;
  logic [SUM_W-1:0] sum;

  logic             accept;
  logic             emit_ok;
  logic [IDX_W-1:0] raddr;
  sample_t          rdata;
  logic             less;
  logic             keep;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quotient;
  sample_t          mean;

  assign accept  = sample_valid && sample_ready;
  assign emit_ok = !result_valid || result_ready;
  assign less    = (rdata < key) || (rdata == key && j < i);
  assign keep    = rank >= CNT_W'(TRIM) && rank < CNT_W'(SAMPLE_COUNT - TRIM);
  assign mean    = quotient[SAMPLE_W-1:0];

  tmlc_sample_mem #(
    .DEPTH (SAMPLE_COUNT)
  ) u_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (fill),
    .wdata (sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmlc_divider #(
    .DATA_W  (SUM_W),
    .DIVISOR (MID_COUNT)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && fill == LAST) begin
          state_next = S_KEY;
        end
      end
      S_KEY:       state_next = S_CMP;
      S_CMP: begin
        if (j == LAST) begin
          state_next = S_ACC;
        end
      end
      S_ACC:       state_next = (i == LAST) ? S_DIV_START : S_KEY;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    div_start    = 1'b0;
    raddr        = '0;
    case (state)
      S_IDLE:      sample_ready = 1'b1;
      S_KEY:       raddr = '0;
      S_CMP:       raddr = (j == LAST) ? '0 : j + IDX_W'(1);
      S_ACC:       raddr = (i == LAST) ? '0 : i + IDX_W'(1);
      S_DIV_START: div_start = 1'b1;
      default:     raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill <= (fill == LAST) ? '0 : fill + IDX_W'(1);
      end
      if (state == S_EMIT && emit_ok) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        i   <= '0;
        sum <= '0;
      end
      S_KEY: begin
        key  <= rdata;
        j    <= '0;
        rank <= '0;
      end
      S_CMP: begin
        j    <= j + IDX_W'(1);
        rank <= rank + CNT_W'(less);
      end
      S_ACC: begin
        i <= i + IDX_W'(1);
        if (keep) begin
          sum <= sum + SUM_W'(key);
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          trimmed_mean  <= mean;
          light_level   <= classify(mean, dark_limit, shady_limit, medium_limit,
                                    light_limit);
          water_present <= mean > water_threshold;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_limit      <= DARK_RST;
      shady_limit     <= SHADY_RST;
      medium_limit    <= MEDIUM_RST;
      light_limit     <= LIGHT_RST;
      water_threshold <= WATER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DARK:   dark_limit      <= cfg_data;
        REG_SHADY:  shady_limit     <= cfg_data;
        REG_MEDIUM: medium_limit    <= cfg_data;
        REG_LIGHT:  light_limit     <= cfg_data;
        REG_WATER:  water_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tmlc_sample_mem.sv
`default_nettype none

module tmlc_sample_mem #(
  parameter int DEPTH = 10
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire tmlc_pkg::sample_t          wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output tmlc_pkg::sample_t               rdata
);
  import tmlc_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/tmlc_divider.sv
`default_nettype none

// divide by a constant through a reciprocal multiply, quotient ready in the cycle after start
module tmlc_divider #(
  parameter int DATA_W  = 17,
  parameter int DIVISOR = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);
  import tmlc_pkg::*;

  // ceil(2^SHIFT / DIVISOR) is exact for every dividend below 2^DATA_W
  localparam int     SHIFT     = DATA_W + $clog2(DIVISOR);
  localparam int     RECIP_W   = SHIFT + 1;
  localparam int     PROD_W    = DATA_W + RECIP_W;
  localparam longint RECIP_VAL = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                 / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  logic [DATA_W-1:0] quo;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(dividend) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= prod[SHIFT +: DATA_W];
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> hw/rtl/tmlc_checker.sv
`default_nettype none

module tmlc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                sample_ready,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire tmlc_pkg::sample_t   trimmed_mean,
  input wire tmlc_pkg::level_t    light_level,
  input wire logic                water_present
);
  import tmlc_pkg::*;

  // held beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(trimmed_mean) && $stable(light_level)
      && $stable(water_present))
    else $error("result beat dropped or changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> sample_ready && !result_valid)
    else $error("not idle after reset");

  a_level: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> light_level <= LVL_BRIGHT)
    else $error("light level out of range");

  // a new result only comes out of a batch pass, during which input is held off
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(sample_ready))
    else $error("result appeared without a batch pass");

endmodule

bind trimmed_mean_level_classifier tmlc_checker u_tmlc_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_ready  (sample_ready),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .trimmed_mean  (trimmed_mean),
  .light_level   (light_level),
  .water_present (water_present)
);

`default_nettype wire

>>> tb/trimmed_mean_level_classifier_tb.sv
`timescale 1ns / 100ps

module trimmed_mean_level_classifier_tb;
  import tmlc_pkg::*;

  localparam int SAMPLE_COUNT = 10;
  localparam int TRIM_DIVIDER = 5;
  localparam int DRAIN_CYCLES = SAMPLE_COUNT * (SAMPLE_COUNT + 2) + 100;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    sample_t mean;
    level_t  level;
    logic    water;
  } level_reading_t;

  typedef struct packed {
    sample_t dark;
    sample_t shady;
    sample_t medium_lim;
    sample_t light;
    sample_t water;
  } limits_t;

  typedef enum {PAT_UNIFORM, PAT_FLAT, PAT_CLUSTER, PAT_EXTREME, PAT_WALK} pattern_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     sample_valid = 1'b0;
  logic     sample_ready;
  sample_t  sample = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  sample_t  trimmed_mean;
  level_t   light_level;
  logic     water_present;
  logic     cfg_write = 1'b0;
  cfg_idx_t cfg_index = REG_DARK;
  sample_t  cfg_data = '0;

  limits_t        limits_now = '{DARK_RST, SHADY_RST, MEDIUM_RST, LIGHT_RST, WATER_RST};
  sample_t        batch_buf [SAMPLE_COUNT];
  int unsigned    batch_fill = 0;
  level_reading_t readings_due [$];
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  pattern_t       pattern_mode = PAT_UNIFORM;
  sample_t        pattern_base = '0;

  trimmed_mean_level_classifier #(
    .SAMPLE_COUNT(SAMPLE_COUNT),
    .TRIM_DIVIDER(TRIM_DIVIDER)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .trimmed_mean(trimmed_mean),
    .light_level(light_level),
    .water_present(water_present),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  function automatic level_t grade_level(input sample_t mean);
    if (mean <= limits_now.dark) return LVL_DARK;
    if (mean <= limits_now.shady) return LVL_SHADY;
    if (mean <= limits_now.medium_lim) return LVL_MEDIUM;
    if (mean <= limits_now.light) return LVL_LIGHT;
    return LVL_BRIGHT;
  endfunction

  // batch fill, insertion sort, trim both ends, truncating mean
  function automatic void absorb_sample(input sample_t s);
    sample_t        ranked [SAMPLE_COUNT];
    sample_t        key;
    int             i;
    int             j;
    int             drop;
    int             kept;
    int unsigned    total;
    level_reading_t r;
    batch_buf[batch_fill] = s;
    batch_fill++;
    if (batch_fill < SAMPLE_COUNT) return;
    batch_fill = 0;
    ranked = batch_buf;
    for (i = 1; i < SAMPLE_COUNT; i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    drop = SAMPLE_COUNT / TRIM_DIVIDER;
    kept = (SAMPLE_COUNT > 2 * drop) ? SAMPLE_COUNT - 2 * drop : 1;
    total = 0;
    for (i = drop; i < SAMPLE_COUNT - drop; i++) total += 32'(ranked[i]);
    r.mean  = sample_t'(total / kept);
    r.level = grade_level(r.mean);
    r.water = (r.mean > limits_now.water);
    readings_due.push_back(r);
  endfunction

  function automatic sample_t clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
    return sample_t'(v);
  endfunction

  function automatic sample_t near_limit();
    int v;
    case ($urandom_range(4))
      0: v = int'(limits_now.dark);
      1: v = int'(limits_now.shady);
      2: v = int'(limits_now.medium_lim);
      3: v = int'(limits_now.light);
      default: v = int'(limits_now.water);
    endcase
    return clamp_sample(v + int'($urandom_range(2)) - 1);
  endfunction

  // a new pattern is chosen at every batch start
  function automatic sample_t next_sample();
    int unsigned pick;
    sample_t     v;
    if (batch_fill == 0) begin
      pick = $urandom_range(99);
      if (pick < 35) pattern_mode = PAT_UNIFORM;
      else if (pick < 60) pattern_mode = PAT_FLAT;
      else if (pick < 80) pattern_mode = PAT_CLUSTER;
      else if (pick < 90) pattern_mode = PAT_EXTREME;
      else pattern_mode = PAT_WALK;
      pattern_base = $urandom_range(1) ? near_limit() : sample_t'($urandom_range(SAMPLE_MAX));
    end
    case (pattern_mode)
      PAT_FLAT: begin
        if ($urandom_range(99) < 15) v = $urandom_range(1) ? sample_t'(SAMPLE_MAX) : '0;
        else v = pattern_base;
      end
      PAT_CLUSTER: v = clamp_sample(int'(pattern_base) + int'($urandom_range(16)) - 8);
      PAT_EXTREME: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = sample_t'(1);
          2: v = sample_t'(SAMPLE_MAX - 1);
          default: v = sample_t'(SAMPLE_MAX);
        endcase
      end
      PAT_WALK: begin
        v = sample_t'(1) << $urandom_range(SAMPLE_W - 1);
        if ($urandom_range(1)) v = ~v;
      end
      default: v = sample_t'($urandom_range(SAMPLE_MAX));
    endcase
    return v;
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    absorb_sample(s);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_sample(next_sample());
    sample_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input sample_t value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_DARK:   limits_now.dark       = value;
      REG_SHADY:  limits_now.shady      = value;
      REG_MEDIUM: limits_now.medium_lim = value;
      REG_LIGHT:  limits_now.light      = value;
      REG_WATER:  limits_now.water      = value;
      default: ;
    endcase
  endtask

  task automatic program_limits(input limits_t l);
    wait_quiet();
    put_reg(REG_DARK, l.dark);
    put_reg(REG_SHADY, l.shady);
    put_reg(REG_MEDIUM, l.medium_lim);
    put_reg(REG_LIGHT, l.light);
    put_reg(REG_WATER, l.water);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input limits_t l, input int unsigned idle, input int unsigned stall,
                           input int n);
    program_limits(l);
    idle_pct  = idle;
    stall_pct = stall;
    run_random(n);
  endtask

  // outliers at both ends, mean on the water limit, then full scale, then a partial batch of zeros
  task automatic test_directed();
    sample_t outliers [SAMPLE_COUNT];
    outliers = '{SAMPLE_MAX, 0, 1000, 1000, SAMPLE_MAX, 1000, 1000, 0, 1000, 1000};
    foreach (outliers[i]) send_sample(outliers[i]);
    repeat (SAMPLE_COUNT) send_sample(sample_t'(SAMPLE_MAX));
    repeat (5) send_sample('0);
    sample_valid <= 1'b0;
  endtask

  task automatic test_unused_index();
    int i;
    wait_quiet();
    for (i = int'(REG_WATER) + 1; i < (1 << CFG_IDX_W); i++) begin
      put_reg(cfg_idx_t'(i), sample_t'($urandom_range(SAMPLE_MAX)));
    end
    cfg_write <= 1'b0;
    run_random(20);
  endtask

  task automatic test_streaming();
    run_phase('{DARK_RST, SHADY_RST, MEDIUM_RST, LIGHT_RST, WATER_RST}, 0, 0, 300);
  endtask

  task automatic test_sender_gaps();
    run_phase('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 86, 0, 250);
  endtask

  task automatic test_receiver_stalls();
    run_phase('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX}, 0, 86, 250);
  endtask

  task automatic test_unordered_limits();
    run_phase('{12'd3000, 12'd2000, 12'd1000, 12'd500, 12'd2047}, 17, 17, 250);
  endtask

  task automatic test_random_limits();
    limits_t l;
    l.dark       = sample_t'($urandom_range(1000));
    l.shady      = l.dark + sample_t'($urandom_range(1000));
    l.medium_lim = l.shady + sample_t'($urandom_range(1000));
    l.light      = l.medium_lim + sample_t'($urandom_range(1000));
    l.water      = sample_t'($urandom_range(SAMPLE_MAX));
    run_phase(l, 17, 17, 250);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result beat check, then a new ready decision for the next cycle
  always @(posedge clk) begin : result_check
    level_reading_t want;
    if (!rst && result_valid && result_ready) begin
      if (readings_due.size() == 0) begin
        note_error($sformatf("unexpected result: mean %0d level %0d water %0d",
                             trimmed_mean, light_level, water_present));
      end else begin
        want = readings_due.pop_front();
        if (trimmed_mean !== want.mean || light_level !== want.level ||
            water_present !== want.water) begin
          note_error($sformatf("mean %0d/%0d level %0d/%0d water %0d/%0d (exp/got)",
                               want.mean, trimmed_mean, want.level, light_level,
                               want.water, water_present));
        end
      end
    end
    result_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_unused_index();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_unordered_limits();
    test_random_limits();
    wait_quiet();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tmlc_pkg.sv
hw/rtl/tmlc_sample_mem.sv
hw/rtl/tmlc_divider.sv
hw/rtl/trimmed_mean_level_classifier.sv
hw/rtl/tmlc_checker.sv
tb/trimmed_mean_level_classifier_tb.sv
